/* hdl/cst_pkg.sv */
// Shared types and constants for the client session table with idle timeout.
// No dependencies; used by cst_cell and the top level.
package cst_pkg;

  // Fixed field widths of the stream payloads and the config register
  localparam int unsigned IP_W    = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned MSG_W   = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 48;

  // Command codes carried in the slave tuser bit
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Reset value of the idle timeout in seconds
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd30;

  // Flags that travel with the scan token from one cell to the next
  typedef struct packed {
    logic act;   // token present in this stage
    logic hit;   // a matching entry has been seen
    logic free;  // a free entry has been seen
  } cst_flags_t;

  // Top level sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } cst_state_e;

endpackage

/* hdl/cst_cell.sv */
// One session slot of the chain: holds a key, a last-seen time and a valid bit,
// and passes the scan token with its running results to the next cell. Uses cst_pkg.
module cst_cell
  import cst_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned MY_INDEX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item broadcast, stable during a scan
  input  logic                 tick_i,
  input  logic [IP_W-1:0]      key_ip_i,
  input  logic [PORT_W-1:0]    key_port_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TMO_W-1:0]     timeout_i,
  // allocation write after a scan
  input  logic                 alloc_we_i,
  input  logic [IDX_W-1:0]     alloc_idx_i,
  // token from the previous cell
  input  cst_flags_t           flags_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [IDX_W-1:0]     free_idx_i,
  input  logic [CNT_W-1:0]     cnt_i,
  // token to the next cell
  output cst_flags_t           flags_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  output logic [CNT_W-1:0]     cnt_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(MY_INDEX);

  logic                 valid_q, valid_d;
  logic [IP_W-1:0]      ip_q, ip_d;
  logic [PORT_W-1:0]    port_q, port_d;
  logic [TIME_BITS-1:0] seen_q, seen_d;
  logic                 act_q;
  logic                 hit_q, hit_d;
  logic                 free_q, free_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic                 match_w;
  logic                 stale_w;
  logic                 own_free_w;
  logic [TIME_BITS-1:0] age_w;

  // Compare the key and measure the modular age of this entry
  assign match_w    = valid_q && (ip_q == key_ip_i) && (port_q == key_port_i);
  assign age_w      = now_i - seen_q;
  assign stale_w    = valid_q &&
                      ({{TMO_W{1'b0}}, age_w} > {{TIME_BITS{1'b0}}, timeout_i});
  assign own_free_w = !valid_q && !flags_i.free;

  // Update the entry when the token passes, or on an allocation write
  always_comb begin
    valid_d = valid_q;
    ip_d    = ip_q;
    port_d  = port_q;
    seen_d  = seen_q;
    if (flags_i.act) begin
      if (tick_i == CMD_TICK) begin
        if (stale_w) begin
          valid_d = 1'b0;
        end
      end else if (match_w) begin
        seen_d = now_i;
      end
    end
    if (alloc_we_i && (alloc_idx_i == MY_IDX)) begin
      valid_d = 1'b1;
      ip_d    = key_ip_i;
      port_d  = key_port_i;
      seen_d  = now_i;
    end
  end

  // Fold this cell into the running results
  always_comb begin
    hit_d      = flags_i.hit;
    hit_idx_d  = hit_idx_i;
    free_d     = flags_i.free;
    free_idx_d = free_idx_i;
    cnt_d      = cnt_i;
    if (tick_i == CMD_TICK) begin
      if (stale_w) begin
        cnt_d = cnt_i + CNT_W'(1);
      end
    end else begin
      if (match_w) begin
        hit_d     = 1'b1;
        hit_idx_d = MY_IDX;
      end
      if (own_free_w) begin
        free_d     = 1'b1;
        free_idx_d = MY_IDX;
      end
    end
  end

  // Control state: valid bit and token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      act_q   <= flags_i.act;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    ip_q   <= ip_d;
    port_q <= port_d;
    seen_q <= seen_d;
  end

  // Hold the token payload once it has passed
  always_ff @(posedge clk_i) begin
    if (flags_i.act) begin
      hit_q      <= hit_d;
      free_q     <= free_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
      cnt_q      <= cnt_d;
    end
  end

  assign flags_o    = '{act: act_q, hit: hit_q, free: free_q};
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign cnt_o      = cnt_q;

endmodule

/* hdl/client_session_table_with_timeout.sv */
// Top level of the client session table with idle timeout: sequencer, counters,
// output register and a chain of cst_cell slots. Uses cst_pkg.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  s_axis    | tvalid_i / tready_o       | tuser: command; tdata: client_ip, port
//  m_axis    | tvalid_o / tready_i       | tdata: accepted .. expired_count
//  cfg       | cfg_we_i                  | cfg_wdata_i: idle_timeout_seconds
//
// A scan token walks the slot chain one cell a cycle. The next input is taken once
// the sequencer is back in idle, and the result is loaded into the output register
// when the token leaves the last cell and the output register is free.
// Reset clears all valid bits, both counters and sets the timeout to 30 seconds.
// A result waiting in the output register does not block the next input; only a
// finished scan meeting a full output register waits until the result is taken.
module client_session_table_with_timeout
  import cst_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] client_ip, [47:32] client_port
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // [0] command
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] accepted, [1] newly_added, [5:2] slot_index, [37:6] message_number,
  // [42:38] expired_count, [47:43] zero
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [TMO_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  cst_state_e           state_q, state_d;
  logic                 start_q;
  logic                 cmd_q;
  logic [IP_W-1:0]      ip_q;
  logic [PORT_W-1:0]    port_q;
  logic [TIME_BITS-1:0] seconds_q;
  logic [MSG_W-1:0]     total_q;
  logic [TMO_W-1:0]     timeout_q;
  logic                 out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0]  out_data_q;

  logic                 in_xfer_w;
  logic                 out_free_w;
  logic                 load_w;
  logic                 alloc_we_w;
  logic [M_DATA_W-1:0]  result_w;
  logic                 res_acc_w;
  logic                 res_new_w;
  logic [IDX_W-1:0]     res_idx_w;
  logic [IDX_W+SLOT_W-1:0] slot_ext_w;
  logic [CNT_W+EXP_W-1:0]  exp_ext_w;
  logic [SLOTS-1:0]     act_vec_w;

  cst_flags_t           flags_w    [SLOTS+1];
  logic [IDX_W-1:0]     hit_idx_w  [SLOTS+1];
  logic [IDX_W-1:0]     free_idx_w [SLOTS+1];
  logic [CNT_W-1:0]     cnt_w      [SLOTS+1];

  assign in_xfer_w  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free_w = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Inject the token at the head of the chain
  assign flags_w[0]    = '{act: start_q, hit: 1'b0, free: 1'b0};
  assign hit_idx_w[0]  = '0;
  assign free_idx_w[0] = '0;
  assign cnt_w[0]      = '0;

  // Slot chain
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    cst_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .MY_INDEX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tick_i      (cmd_q),
      .key_ip_i    (ip_q),
      .key_port_i  (port_q),
      .now_i       (seconds_q),
      .timeout_i   (timeout_q),
      .alloc_we_i  (alloc_we_w),
      .alloc_idx_i (free_idx_w[SLOTS]),
      .flags_i     (flags_w[g]),
      .hit_idx_i   (hit_idx_w[g]),
      .free_idx_i  (free_idx_w[g]),
      .cnt_i       (cnt_w[g]),
      .flags_o     (flags_w[g+1]),
      .hit_idx_o   (hit_idx_w[g+1]),
      .free_idx_o  (free_idx_w[g+1]),
      .cnt_o       (cnt_w[g+1])
    );
    assign act_vec_w[g] = flags_w[g+1].act;
  end

  // Sequence one item through the chain
  always_comb begin
    state_d = state_q;
    load_w  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer_w) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (flags_w[SLOTS].act) begin
          if (out_free_w) begin
            load_w  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free_w) begin
          load_w  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Form the result from the token at the tail
  always_comb begin
    res_acc_w = 1'b0;
    res_new_w = 1'b0;
    res_idx_w = '0;
    if (cmd_q == CMD_PACKET) begin
      if (flags_w[SLOTS].hit) begin
        res_acc_w = 1'b1;
        res_idx_w = hit_idx_w[SLOTS];
      end else if (flags_w[SLOTS].free) begin
        res_acc_w = 1'b1;
        res_new_w = 1'b1;
        res_idx_w = free_idx_w[SLOTS];
      end
    end
  end

  assign alloc_we_w = load_w && res_new_w;
  assign slot_ext_w = {{SLOT_W{1'b0}}, res_idx_w};
  assign exp_ext_w  = (cmd_q == CMD_TICK) ? {{EXP_W{1'b0}}, cnt_w[SLOTS]} : '0;
  assign result_w   = {{(M_DATA_W - EXP_W - MSG_W - SLOT_W - 2){1'b0}},
                       exp_ext_w[EXP_W-1:0], total_q, slot_ext_w[SLOT_W-1:0],
                       res_new_w, res_acc_w};

  // Output register: load on a finished scan, drop on a transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_w) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      seconds_q   <= '0;
      total_q     <= '0;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      state_q     <= state_d;
      start_q     <= in_xfer_w;
      out_valid_q <= out_valid_d;
      if (in_xfer_w) begin
        if (s_axis_tuser_i == CMD_TICK) begin
          seconds_q <= seconds_q + TIME_BITS'(1);
        end else begin
          total_q <= total_q + MSG_W'(1);
        end
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the item key for the length of the scan
  always_ff @(posedge clk_i) begin
    if (in_xfer_w) begin
      cmd_q  <= s_axis_tuser_i;
      ip_q   <= s_axis_tdata_i[IP_W-1:0];
      port_q <= s_axis_tdata_i[IP_W+PORT_W-1:IP_W];
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_w) begin
      out_data_q <= result_w;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // At most one token travels the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({act_vec_w, start_q}))
    else $error("more than one scan token in the slot chain");

  // No input is taken while a scan is still in flight
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !start_q && (act_vec_w == '0))
    else $error("input ready while a scan is in flight");

  // A result with expired entries never reports an accepted packet
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_w && (exp_ext_w[EXP_W-1:0] != '0) |-> !res_acc_w && !res_new_w)
    else $error("expiry count on a packet result");
`endif

endmodule

/* sim/client_session_table_with_timeout_tb.sv */
// Self-checking testbench for client_session_table_with_timeout: a session-table
// predictor, a stream driver fed from an item queue and a checking monitor.
// Depends on cst_pkg and the client_session_table_with_timeout RTL only.
module client_session_table_with_timeout_tb;
  import cst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned PHASES     = 6;
  localparam int unsigned RAND_ITEMS = 130;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned MAX_PRINT  = 40;

  // One input item: command in tuser, {port, ip} in tdata
  typedef struct packed {
    logic              cmd;
    logic [PORT_W-1:0] port;
    logic [IP_W-1:0]   ip;
  } session_item_t;

  // One result, laid out exactly as m_axis_tdata_o
  typedef struct packed {
    logic [M_DATA_W-EXP_W-MSG_W-SLOT_W-3:0] pad;
    logic [EXP_W-1:0]                       expired;
    logic [MSG_W-1:0]                       msg;
    logic [SLOT_W-1:0]                      slot;
    logic                                   added;
    logic                                   acc;
  } session_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = CMD_PACKET;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                cfg_we_i        = 1'b0;
  logic [TMO_W-1:0]    cfg_wdata_i     = '0;

  // Predicted table state
  logic              tbl_valid [SLOT_COUNT];
  logic [IP_W-1:0]   tbl_ip    [SLOT_COUNT];
  logic [PORT_W-1:0] tbl_port  [SLOT_COUNT];
  logic [31:0]       tbl_seen  [SLOT_COUNT];
  logic [31:0]       sec_now   = '0;
  logic [MSG_W-1:0]  pkt_total = '0;
  logic [TMO_W-1:0]  tmo_now   = TIMEOUT_RST;

  session_item_t   pending_items[$];
  session_result_t expected_results[$];
  session_item_t   nxt_item;
  session_result_t got_res;
  session_result_t want_res;

  logic [S_DATA_W-1:0] key_pool[32];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned src_gap      = 0;
  int unsigned snk_gap      = 0;
  int unsigned hold_left    = 0;
  bit          src_idle_en  = 1'b0;
  bit          snk_idle_en  = 1'b0;

  client_session_table_with_timeout #(
    .SLOTS    (SLOT_COUNT),
    .TIME_BITS(32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_port[i]  = '0;
      tbl_seen[i]  = '0;
    end
  end

  // Apply one item to the predicted table and return the result it causes
  function automatic session_result_t session_table_update(logic cmd, logic [IP_W-1:0] ip,
                                                           logic [PORT_W-1:0] port);
    session_result_t r;
    logic [31:0]     age;
    int              slot_hit;
    r        = '0;
    slot_hit = -1;
    if (cmd == CMD_TICK) begin
      // advance time first, then age every live entry against the new value
      sec_now = sec_now + 32'd1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        age = sec_now - tbl_seen[i];
        if (tbl_valid[i] && age > {16'd0, tmo_now}) begin
          tbl_valid[i] = 1'b0;
          r.expired    = r.expired + 5'd1;
        end
      end
      r.msg = pkt_total;
      return r;
    end
    pkt_total = pkt_total + 32'd1;
    r.msg     = pkt_total;
    // refresh a matching session
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_hit < 0 && tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == port) begin
        slot_hit = i;
      end
    end
    if (slot_hit >= 0) begin
      tbl_seen[slot_hit] = sec_now;
      r.acc              = 1'b1;
      r.slot             = slot_hit[SLOT_W-1:0];
      return r;
    end
    // otherwise take the lowest free slot, or refuse when full
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_hit < 0 && !tbl_valid[i]) begin
        slot_hit = i;
      end
    end
    if (slot_hit >= 0) begin
      tbl_valid[slot_hit] = 1'b1;
      tbl_ip[slot_hit]    = ip;
      tbl_port[slot_hit]  = port;
      tbl_seen[slot_hit]  = sec_now;
      r.acc               = 1'b1;
      r.added             = 1'b1;
      r.slot              = slot_hit[SLOT_W-1:0];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < MAX_PRINT) begin
      $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Driver: present pending items, predict each one on its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(session_table_update(s_axis_tuser_i,
                                                        s_axis_tdata_i[IP_W-1:0],
                                                        s_axis_tdata_i[S_DATA_W-1:IP_W]));
        if (src_idle_en) src_gap = pick_gap();
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt_item = pending_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= nxt_item.cmd;
          s_axis_tdata_i  <= {nxt_item.port, nxt_item.ip};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then decide the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_res = session_result_t'(m_axis_tdata_o);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_axis_tdata_o), '0);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.acc !== want_res.acc)
            report_mismatch("accepted", 64'(got_res.acc), 64'(want_res.acc));
          if (got_res.added !== want_res.added)
            report_mismatch("newly_added", 64'(got_res.added), 64'(want_res.added));
          if (got_res.slot !== want_res.slot)
            report_mismatch("slot_index", 64'(got_res.slot), 64'(want_res.slot));
          if (got_res.msg !== want_res.msg)
            report_mismatch("message_number", 64'(got_res.msg), 64'(want_res.msg));
          if (got_res.expired !== want_res.expired)
            report_mismatch("expired_count", 64'(got_res.expired), 64'(want_res.expired));
          if (got_res.pad !== want_res.pad)
            report_mismatch("padding", 64'(got_res.pad), 64'(want_res.pad));
        end
        results_seen++;
        // hold off for a long stretch so the table backs up into its input
        if (results_seen == 150 || results_seen == 500) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (snk_gap != 0) begin
        snk_gap--;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        snk_gap = pick_gap();
      end
      m_axis_tready_i <= (hold_left == 0 && snk_gap == 0);
    end
  end

  task automatic queue_item(input logic cmd, input logic [IP_W-1:0] ip,
                            input logic [PORT_W-1:0] port);
    session_item_t it;
    it.cmd  = cmd;
    it.ip   = ip;
    it.port = port;
    pending_items.push_back(it);
  endtask

  // Hold until every item has gone in and every result has come out
  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SLOT_COUNT + 4) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tmo_now      = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Build a key pool; every third key shares its address with the one before
  task automatic fill_pool(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      key_pool[i][IP_W-1:0]        = (i % 3 == 2) ? key_pool[i-1][IP_W-1:0] : $urandom;
      key_pool[i][S_DATA_W-1:IP_W] = PORT_W'($urandom_range(0, 65535));
    end
  endtask

  task automatic queue_random(input int unsigned count, input int unsigned tick_pct,
                              input int unsigned pool_n);
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        queue_item(CMD_TICK, $urandom, PORT_W'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 19) == 0) begin
        queue_item(CMD_PACKET, $urandom, PORT_W'($urandom_range(0, 65535)));
      end else begin
        k = $urandom_range(0, pool_n - 1);
        queue_item(CMD_PACKET, key_pool[k][IP_W-1:0], key_pool[k][S_DATA_W-1:IP_W]);
      end
    end
  endtask

  initial begin
    logic [TMO_W-1:0] tmo_plan [PHASES];
    int unsigned      pool_plan[PHASES];
    int unsigned      tick_plan[PHASES];

    tmo_plan  = '{16'hFFFF, 16'd3, 16'd0, 16'd1, 16'd0, TIMEOUT_RST};
    pool_plan = '{24, 20, 12, 18, 30, 22};
    tick_plan = '{5, 20, 25, 30, 15, 10};
    tmo_plan[4] = TMO_W'($urandom_range(2, 12));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme keys, a match, keys differing in one half only
    queue_item(CMD_PACKET, 32'h0000_0000, 16'h0000);
    queue_item(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF);
    queue_item(CMD_PACKET, 32'h0000_0000, 16'h0000);
    queue_item(CMD_PACKET, 32'h0000_0000, 16'hFFFF);
    queue_item(CMD_PACKET, 32'hFFFF_FFFF, 16'h0000);
    // fill the rest of the table, then hit it when full
    for (int i = 4; i < SLOT_COUNT; i++)
      queue_item(CMD_PACKET, 32'hA5A5_0000 + 32'(i), PORT_W'(i));
    queue_item(CMD_PACKET, 32'h5A5A_5A5A, 16'h1234);
    queue_item(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF);
    // a tick under the reset timeout expires nothing
    queue_item(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();

    // zero timeout: the next tick clears the whole table, then slot 0 is reused
    write_timeout(16'd0);
    queue_item(CMD_TICK, 32'h0000_0000, 16'h0000);
    queue_item(CMD_PACKET, 32'h1234_5678, 16'h9ABC);
    wait_drained();

    // Random phases, each under its own timeout and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      write_timeout(tmo_plan[ph]);
      src_idle_en = (ph != 2 && ph != 3);
      snk_idle_en = (ph != 1 && ph != 2);
      fill_pool(pool_plan[ph]);
      queue_random(RAND_ITEMS, tick_plan[ph], pool_plan[ph]);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("client_session_table_with_timeout regression: pass");
    end else begin
      $display("client_session_table_with_timeout regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("client_session_table_with_timeout regression: fail");
    $finish;
  end

endmodule
